>>> hw/rtl/lcs_pkg.sv
`default_nettype none
package lcs_pkg;

   // fixed field widths
   localparam int IN_BITS    = 24;
   localparam int PIX_BITS   = 16;
   localparam int COLOR_BITS = 32;

   // width used for outcode compares, wide enough for any coordinate or edge
   localparam int OC_W = 48;

   // outcode bits
   localparam logic [3:0] OC_LEFT   = 4'd1;
   localparam logic [3:0] OC_RIGHT  = 4'd2;
   localparam logic [3:0] OC_BOTTOM = 4'd4;
   localparam logic [3:0] OC_TOP    = 4'd8;

   // register indexes
   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_RIGHT  = 2'd1;
   localparam logic [1:0] REG_BOTTOM = 2'd2;
   localparam logic [1:0] REG_TOP    = 2'd3;

   typedef logic signed [OC_W-1:0] lcs_wide_type;

   typedef struct packed {
      logic signed [IN_BITS-1:0] start_x;
      logic signed [IN_BITS-1:0] start_y;
      logic signed [IN_BITS-1:0] end_x;
      logic signed [IN_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0]     line_color;
   } lcs_req_type;

   typedef struct packed {
      logic                       accepted;
      logic signed [PIX_BITS-1:0] clip_start_x;
      logic signed [PIX_BITS-1:0] clip_start_y;
      logic signed [PIX_BITS-1:0] clip_end_x;
      logic signed [PIX_BITS-1:0] clip_end_y;
      logic [COLOR_BITS-1:0]      out_color;
   } lcs_rsp_type;

   // per-beat control carried down the pipeline
   typedef struct packed {
      logic valid;
      logic done;
      logic acc;
   } lcs_ctrl_type;

   function automatic logic [3:0] outcode(lcs_wide_type x, lcs_wide_type y,
                                          lcs_wide_type l, lcs_wide_type r,
                                          lcs_wide_type b, lcs_wide_type t);
      logic [3:0] c;
      c = 4'd0;
      if (x < l) c = c | OC_LEFT;
      else if (x > r) c = c | OC_RIGHT;
      if (y < b) c = c | OC_BOTTOM;
      else if (y > t) c = c | OC_TOP;
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lcs_divider.sv
`default_nettype none
module lcs_divider #(
   parameter int DW  = 26,
   parameter int QW  = 26,
   parameter int PLW = 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [DW-1:0]  in_rem,
   input  wire logic [DW-1:0]  in_den,
   input  wire logic [QW-1:0]  in_low,
   input  wire logic [PLW-1:0] in_pay,
   output logic                out_valid,
   output logic [QW-1:0]       out_quot,
   output logic [PLW-1:0]      out_pay
);

   logic           valid_ff [QW];
   logic [DW-1:0]  rem_ff [QW];
   logic [DW-1:0]  den_ff [QW];
   logic [QW-1:0]  low_ff [QW];
   logic [PLW-1:0] pay_ff [QW];

   // one quotient bit per stage; low word shifts quotient in at the bottom
   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic           v_prev;
      logic [DW-1:0]  rem_prev;
      logic [DW-1:0]  den_prev;
      logic [QW-1:0]  low_prev;
      logic [PLW-1:0] pay_prev;
      logic [DW:0]    trial;
      logic           take;
      logic [DW-1:0]  rem_in;
      logic [QW-1:0]  low_in;

      if (i == 0) begin : g_first
         assign v_prev   = in_valid;
         assign rem_prev = in_rem;
         assign den_prev = in_den;
         assign low_prev = in_low;
         assign pay_prev = in_pay;
      end else begin : g_next
         assign v_prev   = valid_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign pay_prev = pay_ff[i-1];
      end

      // trial subtract
      always_comb begin
         trial  = {rem_prev, low_prev[QW-1]};
         take   = (trial >= {1'b0, den_prev});
         rem_in = take ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
         low_in = {low_prev[QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
            low_ff[i] <= low_in;
            pay_ff[i] <= pay_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = low_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule
`default_nettype wire

>>> hw/rtl/lcs_round.sv
`default_nettype none
module lcs_round #(
   parameter int XW = 25
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire lcs_pkg::lcs_ctrl_type        in_ctrl,
   input  wire logic [3:0][XW-1:0]           in_pts,
   input  wire logic [lcs_pkg::COLOR_BITS-1:0] in_color,
   input  wire logic signed [XW-1:0]         edge_l,
   input  wire logic signed [XW-1:0]         edge_r,
   input  wire logic signed [XW-1:0]         edge_b,
   input  wire logic signed [XW-1:0]         edge_t,
   output lcs_pkg::lcs_ctrl_type             out_ctrl,
   output logic [3:0][XW-1:0]                out_pts,
   output logic [lcs_pkg::COLOR_BITS-1:0]    out_color
);

   localparam int DW = XW + 1;
   localparam int QW = XW + 1;
   localparam int NW = 2 * XW + 2;

   typedef struct packed {
      logic [3:0][XW-1:0]                pts;
      logic [lcs_pkg::COLOR_BITS-1:0]    color;
      logic                              done;
      logic                              acc;
      logic                              first;
      logic                              vert;
      logic                              neg;
      logic signed [XW-1:0]              edge_v;
      logic signed [XW-1:0]              base;
   } pay_type;

   localparam int PLW = $bits(pay_type);

   // decide stage: outcodes, edge choice, differences
   logic [3:0]           c1, c2, co;
   logic signed [XW-1:0] x1, y1, x2, y2, ev;
   logic signed [XW:0]   d_c, eq_c, den_c;
   pay_type              pay_c;

   always_comb begin
      x1 = $signed(in_pts[0]);
      y1 = $signed(in_pts[1]);
      x2 = $signed(in_pts[2]);
      y2 = $signed(in_pts[3]);
      c1 = lcs_pkg::outcode(lcs_pkg::lcs_wide_type'(x1), lcs_pkg::lcs_wide_type'(y1),
                            lcs_pkg::lcs_wide_type'(edge_l), lcs_pkg::lcs_wide_type'(edge_r),
                            lcs_pkg::lcs_wide_type'(edge_b), lcs_pkg::lcs_wide_type'(edge_t));
      c2 = lcs_pkg::outcode(lcs_pkg::lcs_wide_type'(x2), lcs_pkg::lcs_wide_type'(y2),
                            lcs_pkg::lcs_wide_type'(edge_l), lcs_pkg::lcs_wide_type'(edge_r),
                            lcs_pkg::lcs_wide_type'(edge_b), lcs_pkg::lcs_wide_type'(edge_t));
      co = (c1 != 4'd0) ? c1 : c2;
      pay_c.pts   = in_pts;
      pay_c.color = in_color;
      pay_c.first = (c1 != 4'd0);
      pay_c.vert  = ((co & (lcs_pkg::OC_TOP | lcs_pkg::OC_BOTTOM)) != 4'd0);
      pay_c.neg   = 1'b0;
      if (pay_c.vert) begin
         ev    = ((co & lcs_pkg::OC_TOP) != 4'd0) ? edge_t : edge_b;
         d_c   = (XW+1)'(x2) - (XW+1)'(x1);
         eq_c  = (XW+1)'(ev) - (XW+1)'(y1);
         den_c = (XW+1)'(y2) - (XW+1)'(y1);
         pay_c.base = x1;
      end else begin
         ev    = ((co & lcs_pkg::OC_RIGHT) != 4'd0) ? edge_r : edge_l;
         d_c   = (XW+1)'(y2) - (XW+1)'(y1);
         eq_c  = (XW+1)'(ev) - (XW+1)'(x1);
         den_c = (XW+1)'(x2) - (XW+1)'(x1);
         pay_c.base = y1;
      end
      pay_c.edge_v = ev;
      // resolve trivial cases; finished beats ride through unchanged
      pay_c.done = in_ctrl.done;
      pay_c.acc  = in_ctrl.acc;
      if (!in_ctrl.done) begin
         if (c1 == 4'd0 && c2 == 4'd0) begin
            pay_c.done = 1'b1;
            pay_c.acc  = 1'b1;
         end else if ((c1 & c2) != 4'd0 || den_c == '0) begin
            pay_c.done = 1'b1;
            pay_c.acc  = 1'b0;
         end
      end
   end

   logic               a_valid_ff;
   pay_type            a_pay_ff;
   logic signed [XW:0] a_d_ff, a_eq_ff, a_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pay_ff <= pay_c;
         a_d_ff   <= d_c;
         a_eq_ff  <= eq_c;
         a_den_ff <= den_c;
      end
   end

   // multiply stage
   logic                 b_valid_ff;
   pay_type              b_pay_ff;
   logic signed [NW-1:0] b_prod_ff;
   logic signed [XW:0]   b_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_pay_ff  <= a_pay_ff;
         b_prod_ff <= NW'(a_d_ff) * NW'(a_eq_ff);
         b_den_ff  <= a_den_ff;
      end
   end

   // magnitude stage
   logic          c_valid_ff;
   pay_type       c_pay_ff;
   logic [NW-1:0] c_num_ff;
   logic [DW-1:0] c_den_ff;
   pay_type       pay_mag;

   always_comb begin
      pay_mag     = b_pay_ff;
      pay_mag.neg = b_prod_ff[NW-1] ^ b_den_ff[XW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_pay_ff <= pay_mag;
         c_num_ff <= b_prod_ff[NW-1] ? NW'(-b_prod_ff) : NW'(b_prod_ff);
         c_den_ff <= b_den_ff[XW] ? DW'(-b_den_ff) : DW'(b_den_ff);
      end
   end

   // divide
   logic           dv_valid;
   logic [QW-1:0]  dv_quot;
   logic [PLW-1:0] dv_pay_bits;
   pay_type        dv_pay;

   lcs_divider #(
      .DW  (DW),
      .QW  (QW),
      .PLW (PLW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_rem    (c_num_ff[NW-1:QW]),
      .in_den    (c_den_ff),
      .in_low    (c_num_ff[QW-1:0]),
      .in_pay    (c_pay_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_pay   (dv_pay_bits)
   );

   assign dv_pay = pay_type'(dv_pay_bits);

   // update stage: move the outside endpoint onto the edge
   logic signed [QW:0]   q_s;
   logic signed [XW-1:0] nv, nx, ny;
   logic [3:0][XW-1:0]   pts_in;

   always_comb begin
      q_s    = dv_pay.neg ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
      nv     = XW'(dv_pay.base + XW'(q_s));
      nx     = dv_pay.vert ? nv : dv_pay.edge_v;
      ny     = dv_pay.vert ? dv_pay.edge_v : nv;
      pts_in = dv_pay.pts;
      if (!dv_pay.done) begin
         if (dv_pay.first) begin
            pts_in[0] = nx;
            pts_in[1] = ny;
         end else begin
            pts_in[2] = nx;
            pts_in[3] = ny;
         end
      end
   end

   lcs_pkg::lcs_ctrl_type              ctrl_ff;
   logic [3:0][XW-1:0]                 pts_ff;
   logic [lcs_pkg::COLOR_BITS-1:0]     color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff.valid <= dv_valid;
         ctrl_ff.done  <= dv_pay.done;
         ctrl_ff.acc   <= dv_pay.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pts_ff   <= pts_in;
         color_ff <= dv_pay.color;
      end
   end

   assign out_ctrl  = ctrl_ff;
   assign out_pts   = pts_ff;
   assign out_color = color_ff;

endmodule
`default_nettype wire

>>> hw/rtl/line_clip_cohen_sutherland_top.sv
`default_nettype none
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  lcs_req_type (two endpoints, color)
// rsp       out  rsp_valid/rsp_stall  lcs_rsp_type (accept, clipped ends, color)
// csr       in   csr_we               csr_index, csr_wdata (window edges)
//
// XW is one bit over the wider of the input and fixed-point edge widths. The
// pipeline is an input register, four clip rounds, each a bit-per-stage
// divider behind a multiplier, and an output register.
// A new beat enters every cycle, one result leaves per cycle, unless stalled.
// Reset clears all valid bits and loads the default window.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module line_clip_cohen_sutherland_top #(
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire lcs_pkg::lcs_req_type        req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output lcs_pkg::lcs_rsp_type             rsp_payload,
   input  wire logic                        csr_we,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [lcs_pkg::PIX_BITS-1:0] csr_wdata
);

   localparam int COORD_BITS = lcs_pkg::PIX_BITS;
   localparam int IN = lcs_pkg::IN_BITS;
   localparam int EW = COORD_BITS + FRAC_BITS;
   localparam int XW = ((EW > IN) ? EW : IN) + 1;
   localparam logic signed [XW-1:0] RND = (XW'(1) << FRAC_BITS) - XW'(1);
   localparam int ROUNDS = 4;

   // window registers
   logic signed [COORD_BITS-1:0] win_l_ff, win_r_ff, win_b_ff, win_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_l_ff <= COORD_BITS'(0);
         win_r_ff <= COORD_BITS'(799);
         win_b_ff <= COORD_BITS'(0);
         win_t_ff <= COORD_BITS'(599);
      end else if (csr_we) begin
         case (csr_index)
            lcs_pkg::REG_LEFT:   win_l_ff <= csr_wdata;
            lcs_pkg::REG_RIGHT:  win_r_ff <= csr_wdata;
            lcs_pkg::REG_BOTTOM: win_b_ff <= csr_wdata;
            lcs_pkg::REG_TOP:    win_t_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window edges in fixed point
   logic signed [XW-1:0] edge_l, edge_r, edge_b, edge_t;
   assign edge_l = XW'(win_l_ff) <<< FRAC_BITS;
   assign edge_r = XW'(win_r_ff) <<< FRAC_BITS;
   assign edge_b = XW'(win_b_ff) <<< FRAC_BITS;
   assign edge_t = XW'(win_t_ff) <<< FRAC_BITS;

   // advance everything unless the result is held
   logic en;
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // input register
   lcs_pkg::lcs_ctrl_type          st_ctrl [ROUNDS+1];
   logic [3:0][XW-1:0]             st_pts  [ROUNDS+1];
   logic [lcs_pkg::COLOR_BITS-1:0] st_color[ROUNDS+1];

   lcs_pkg::lcs_ctrl_type          in_ctrl_ff;
   logic [3:0][XW-1:0]             in_pts_ff;
   logic [lcs_pkg::COLOR_BITS-1:0] in_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctrl_ff <= '0;
      end else if (en) begin
         in_ctrl_ff.valid <= req_valid;
         in_ctrl_ff.done  <= 1'b0;
         in_ctrl_ff.acc   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_pts_ff[0] <= XW'(req_payload.start_x);
         in_pts_ff[1] <= XW'(req_payload.start_y);
         in_pts_ff[2] <= XW'(req_payload.end_x);
         in_pts_ff[3] <= XW'(req_payload.end_y);
         in_color_ff  <= req_payload.line_color;
      end
   end

   assign st_ctrl[0]  = in_ctrl_ff;
   assign st_pts[0]   = in_pts_ff;
   assign st_color[0] = in_color_ff;

   // clip rounds
   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      lcs_round #(
         .XW (XW)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_ctrl   (st_ctrl[r]),
         .in_pts    (st_pts[r]),
         .in_color  (st_color[r]),
         .edge_l    (edge_l),
         .edge_r    (edge_r),
         .edge_b    (edge_b),
         .edge_t    (edge_t),
         .out_ctrl  (st_ctrl[r+1]),
         .out_pts   (st_pts[r+1]),
         .out_color (st_color[r+1])
      );
   end

   // final check and pixel truncation
   logic [3:0]            fc1, fc2;
   logic                  acc_c;
   logic signed [XW-1:0]  fv, adj, shv;
   logic [3:0][lcs_pkg::PIX_BITS-1:0] pix;
   lcs_pkg::lcs_rsp_type  rsp_in;

   always_comb begin
      fc1 = lcs_pkg::outcode(
         lcs_pkg::lcs_wide_type'($signed(st_pts[ROUNDS][0])),
         lcs_pkg::lcs_wide_type'($signed(st_pts[ROUNDS][1])),
         lcs_pkg::lcs_wide_type'(edge_l), lcs_pkg::lcs_wide_type'(edge_r),
         lcs_pkg::lcs_wide_type'(edge_b), lcs_pkg::lcs_wide_type'(edge_t));
      fc2 = lcs_pkg::outcode(
         lcs_pkg::lcs_wide_type'($signed(st_pts[ROUNDS][2])),
         lcs_pkg::lcs_wide_type'($signed(st_pts[ROUNDS][3])),
         lcs_pkg::lcs_wide_type'(edge_l), lcs_pkg::lcs_wide_type'(edge_r),
         lcs_pkg::lcs_wide_type'(edge_b), lcs_pkg::lcs_wide_type'(edge_t));
      acc_c = st_ctrl[ROUNDS].done ? st_ctrl[ROUNDS].acc : (fc1 == 4'd0 && fc2 == 4'd0);
      fv  = '0;
      adj = '0;
      shv = '0;
      for (int k = 0; k < 4; k++) begin
         fv     = $signed(st_pts[ROUNDS][k]);
         adj    = fv + (fv[XW-1] ? RND : XW'(0));
         shv    = adj >>> FRAC_BITS;
         pix[k] = acc_c ? shv[lcs_pkg::PIX_BITS-1:0] : '0;
      end
      rsp_in.accepted     = acc_c;
      rsp_in.clip_start_x = pix[0];
      rsp_in.clip_start_y = pix[1];
      rsp_in.clip_end_x   = pix[2];
      rsp_in.clip_end_y   = pix[3];
      rsp_in.out_color    = st_color[ROUNDS];
   end

   // output register
   lcs_pkg::lcs_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= st_ctrl[ROUNDS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // a rejected segment carries zero coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.accepted |->
         rsp_payload.clip_start_x == '0 && rsp_payload.clip_start_y == '0 &&
         rsp_payload.clip_end_x == '0 && rsp_payload.clip_end_y == '0)
      else $error("rejected result with nonzero coordinates");

   // a held result freezes the first pipeline stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(in_ctrl_ff.valid))
      else $error("pipeline moved while stalled");

   // accepted start point lies inside the window
   a_inside_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.accepted |->
         $signed(rsp_payload.clip_start_x) >= win_l_ff &&
         $signed(rsp_payload.clip_start_x) <= win_r_ff)
      else $error("accepted x outside window");

   a_inside_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.accepted |->
         $signed(rsp_payload.clip_start_y) >= win_b_ff &&
         $signed(rsp_payload.clip_start_y) <= win_t_ff)
      else $error("accepted y outside window");
`endif

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
module tb_top;

   localparam int FRAC = 8;
   localparam int PIPE_LAT = 122;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lcs_pkg::lcs_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lcs_pkg::lcs_rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = lcs_pkg::REG_LEFT;
   logic [15:0] csr_wdata = '0;

   // window edges, whole pixels
   longint win_left, win_right, win_bottom, win_top;
   lcs_pkg::lcs_rsp_type clip_expected_q[$];
   int errors = 0;
   int cycles = 0;
   bit hold_off = 1'b0;
   bit no_stall = 1'b0;

   line_clip_cohen_sutherland_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // abort on runaway
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[line_clip_cohen_sutherland_top] ERROR");
         $finish;
      end
   end

   function automatic logic [3:0] region_code(longint x, longint y);
      logic [3:0] c;
      c = 4'd0;
      if (x < win_left * 256) c |= lcs_pkg::OC_LEFT;
      else if (x > win_right * 256) c |= lcs_pkg::OC_RIGHT;
      if (y < win_bottom * 256) c |= lcs_pkg::OC_BOTTOM;
      else if (y > win_top * 256) c |= lcs_pkg::OC_TOP;
      return c;
   endfunction

   function automatic lcs_pkg::lcs_rsp_type clip_segment(lcs_pkg::lcs_req_type r);
      lcs_pkg::lcs_rsp_type o;
      longint x1, y1, x2, y2, nx, ny, den, edge_v;
      logic [3:0] c1, c2, co;
      bit acc;
      bit quit;
      x1 = longint'(r.start_x); y1 = longint'(r.start_y);
      x2 = longint'(r.end_x);   y2 = longint'(r.end_y);
      c1 = region_code(x1, y1); c2 = region_code(x2, y2);
      acc = 1'b0; quit = 1'b0;
      for (int rnd = 0; rnd <= 4 && !quit; rnd++) begin
         if (c1 == 0 && c2 == 0) begin
            acc = 1'b1; quit = 1'b1;
         end else if ((c1 & c2) != 0 || rnd == 4) begin
            quit = 1'b1;
         end else begin
            co = (c1 != 0) ? c1 : c2;
            if (co & (lcs_pkg::OC_TOP | lcs_pkg::OC_BOTTOM)) begin
               edge_v = ((co & lcs_pkg::OC_TOP) ? win_top : win_bottom) * 256;
               den = y2 - y1;
               nx = (den == 0) ? 0 : x1 + ((x2 - x1) * (edge_v - y1)) / den;
               ny = edge_v;
            end else begin
               edge_v = ((co & lcs_pkg::OC_RIGHT) ? win_right : win_left) * 256;
               den = x2 - x1;
               ny = (den == 0) ? 0 : y1 + ((y2 - y1) * (edge_v - x1)) / den;
               nx = edge_v;
            end
            if (den == 0) quit = 1'b1;
            else if (co == c1) begin
               x1 = nx; y1 = ny; c1 = region_code(x1, y1);
            end else begin
               x2 = nx; y2 = ny; c2 = region_code(x2, y2);
            end
         end
      end
      o = '0;
      o.accepted = acc;
      if (acc) begin
         o.clip_start_x = 16'(x1 / (1 << FRAC));
         o.clip_start_y = 16'(y1 / (1 << FRAC));
         o.clip_end_x = 16'(x2 / (1 << FRAC));
         o.clip_end_y = 16'(y2 / (1 << FRAC));
      end
      o.out_color = r.line_color;
      return o;
   endfunction

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      lcs_pkg::lcs_rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clip_expected_q.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_payload);
            errors++;
         end else begin
            exp_r = clip_expected_q.pop_front();
            if (exp_r.accepted !== rsp_payload.accepted ||
                exp_r.clip_start_x !== rsp_payload.clip_start_x ||
                exp_r.clip_start_y !== rsp_payload.clip_start_y ||
                exp_r.clip_end_x !== rsp_payload.clip_end_x ||
                exp_r.clip_end_y !== rsp_payload.clip_end_y ||
                exp_r.out_color !== rsp_payload.out_color) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_r,
                        rsp_payload);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      int phase;
      if (hold_off) rsp_stall <= 1'b1;
      else if (no_stall) rsp_stall <= 1'b0;
      else begin
         phase = cycles % 96;
         rsp_stall <= (phase < 40) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   // offer one beat and hold it until taken; valid stays up for the next beat
   task automatic send_segment(lcs_pkg::lcs_req_type r);
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      clip_expected_q.push_back(clip_segment(r));
   endtask

   // send a burst-shaped stream: gaps between beats only at burst ends
   int burst_left = 0;
   task automatic send_paced(lcs_pkg::lcs_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_segment(r);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (clip_expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(logic [1:0] idx, logic signed [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         lcs_pkg::REG_LEFT: win_left = v;
         lcs_pkg::REG_RIGHT: win_right = v;
         lcs_pkg::REG_BOTTOM: win_bottom = v;
         default: win_top = v;
      endcase
   endtask

   task automatic set_window(int l, int r, int b, int t);
      write_window(lcs_pkg::REG_LEFT, 16'(l));
      write_window(lcs_pkg::REG_RIGHT, 16'(r));
      write_window(lcs_pkg::REG_BOTTOM, 16'(b));
      write_window(lcs_pkg::REG_TOP, 16'(t));
      csr_we <= 1'b0;
   endtask

   function automatic lcs_pkg::lcs_req_type make_seg(int x1, int y1, int x2, int y2,
                                                     logic [31:0] col);
      lcs_pkg::lcs_req_type r;
      r.start_x = 24'(x1); r.start_y = 24'(y1);
      r.end_x = 24'(x2); r.end_y = 24'(y2);
      r.line_color = col;
      return r;
   endfunction

   // coordinate near the window or anywhere in range
   function automatic int pick_coord(longint lo, longint hi);
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return int'($urandom_range(0, 32'(hi - lo + 800)) + lo * 256 - 400) ;
      if (k < 8) return int'(lo * 256 + $urandom_range(0, 512) - 256);
      return int'($signed(24'($urandom)));
   endfunction

   function automatic lcs_pkg::lcs_req_type rand_seg();
      return make_seg(pick_coord(win_left, win_right + (win_right - win_left) * 255),
                      pick_coord(win_bottom, win_top + (win_top - win_bottom) * 255),
                      pick_coord(win_left, win_right + (win_right - win_left) * 255),
                      pick_coord(win_bottom, win_top + (win_top - win_bottom) * 255),
                      $urandom);
   endfunction

   task automatic test_directed();
      // default window after reset
      win_left = 0; win_right = 799; win_bottom = 0; win_top = 599;
      send_segment(make_seg(2560, 2560, 25600, 12800, 32'h0));
      send_segment(make_seg(-5000, 100, -3000, 9000, 32'hFFFF_FFFF));
      send_segment(make_seg(-2560, -2560, 300000, 200000, 32'h1234_5678));
      send_segment(make_seg(100, 200000, 100, -200000, 32'hA5A5_A5A5));
      send_segment(make_seg(-8388608, -8388608, 8388607, 8388607, 32'h5A5A_5A5A));
      send_segment(make_seg(8388607, -8388608, -8388608, 8388607, 32'h8000_0001));
      send_segment(make_seg(204544, 153344, 204544, 153344, 32'h1));
      send_segment(make_seg(204545, 0, 204545, 100, 32'h2));
      send_segment(make_seg(-1, -1, -1, 100000, 32'h3));
      send_segment(make_seg(-300, 153600, 204900, -200, 32'h4));
      send_segment(make_seg(-51200, 76800, 102400, 300000, 32'h5));
      drain_all();
      // extreme window, inverted window, degenerate window
      set_window(-32768, 32767, -32768, 32767);
      send_segment(make_seg(-8388608, 8388607, 8388607, -8388608, 32'h6));
      send_segment(make_seg(-1000, -255, 255, 1000, 32'h7));
      drain_all();
      set_window(100, -100, 50, -50);
      send_segment(make_seg(0, 0, 1000, 1000, 32'h8));
      send_segment(make_seg(-30000, 0, 30000, 0, 32'h9));
      drain_all();
      set_window(5, 5, -7, -7);
      send_segment(make_seg(0, -3000, 3000, 0, 32'hA));
      send_segment(make_seg(1280, -1792, 1280, -1792, 32'hB));
      drain_all();
   endtask

   task automatic test_random_windows();
      int l, r, b, t;
      for (int ph = 0; ph < 6; ph++) begin
         l = $urandom_range(0, 600) - 300; r = l + $urandom_range(0, 900);
         b = $urandom_range(0, 600) - 300; t = b + $urandom_range(0, 900);
         if (ph == 5) begin
            l = $urandom_range(0, 200); r = l - 10;
         end
         set_window(l, r, b, t);
         repeat (25) send_paced(rand_seg());
         drain_all();
      end
   endtask

   task automatic test_backpressure();
      set_window(-32768, 32767, -32768, 32767);
      set_window(-50, 700, -20, 500);
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (200) send_segment(rand_seg());
            drain_all();
         end
      join
      // sender pauses until everything is back, then goes on with no stalls
      no_stall = 1'b1;
      repeat (30) send_segment(rand_seg());
      no_stall = 1'b0;
      drain_all();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_windows();
      test_backpressure();
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (errors == 0 && clip_expected_q.size() == 0)
         $display("[line_clip_cohen_sutherland_top] OK");
      else
         $display("[line_clip_cohen_sutherland_top] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_divider.sv
hw/rtl/lcs_round.sv
hw/rtl/line_clip_cohen_sutherland_top.sv
sim/tb_top.sv
